/* rtl/hpsm_pkg.sv */
// Shared types, constants and width helpers for the Hall period speed meter.
`timescale 1ns / 1ps

package hpsm_pkg;

  localparam int CIRC_W    = 12;
  localparam int PPR_W     = 7;
  localparam int PERIOD_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CLK_W     = 32;
  localparam int SPEED_W   = 16;
  localparam int ACCEL_W   = 24;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CIRC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  localparam logic [CIRC_W-1:0]   CIRC_RST   = 12'd1500;
  localparam logic [PPR_W-1:0]    PPR_RST    = 7'd1;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd500;

  // speed = 360 * circ / (ppr * avg); 360 * 4095 fits 21 bits
  localparam int                SPEED_NUM_W = 21;
  localparam logic [8:0]        SPEED_SCALE = 9'd360;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 16'hFFFF;

  // accel = dspeed * 25000 / (9 * period); |dspeed| * 25000 fits 31 bits
  localparam int          ACC_PROD_W    = 31;
  localparam logic [14:0] ACC_SCALE     = 15'd25000;
  localparam int          ACC_DVS_W     = 20;
  localparam logic [3:0]  ACC_DVS_SCALE = 4'd9;

  localparam int unsigned ACCEL_MAX_MAG = 32'd8388607;
  localparam int unsigned ACCEL_MIN_MAG = 32'd8388608;
  localparam logic [ACCEL_W-1:0] ACCEL_POS_SAT = 24'h7FFFFF;
  localparam logic [ACCEL_W-1:0] ACCEL_NEG_SAT = 24'h800000;

  typedef struct packed {
    logic [CIRC_W-1:0]   wheel_circumference_mm;
    logic [PPR_W-1:0]    pulses_per_rev;
    logic [PERIOD_W-1:0] update_period_ms;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_AVG,
    B_DEN,
    B_SPEED,
    B_ACC_MUL,
    B_ACC_START,
    B_ACC_DIV,
    B_OUT
  } back_state_t;

  function automatic int pos_width(input int samples);
    return (samples > 1) ? $clog2(samples) : 1;
  endfunction

  function automatic int sum_width(input int samples, input int ib);
    return ib + pos_width(samples);
  endfunction

  function automatic int divd_width(input int samples, input int ib);
    int w;
    w = sum_width(samples, ib);
    if (w < ACC_PROD_W) w = ACC_PROD_W;
    if (w < SPEED_NUM_W) w = SPEED_NUM_W;
    return w;
  endfunction

  function automatic int dvs_width(input int ib);
    return (PPR_W + ib > ACC_DVS_W) ? PPR_W + ib : ACC_DVS_W;
  endfunction

endpackage

/* rtl/hall_period_speed_meter.sv */
// Top level of the Hall period speed meter: config registers, front, queue, back, divider.
`timescale 1ns / 1ps
// Flow: an item that causes no recomputation goes from the queue into the result register;
//   a recomputing item is popped and then passes the average, denominator, speed divide,
//   accel multiply, accel start, accel divide and output states, skipping the speed divide
//   when the denominator is zero. Items behind a recompute wait for it.
// Throughput: one item per cycle while no recomputation runs and the result is not
//   stalled; the two-entry queue takes up to two more items while the back divides. Reset
//   (rst, synchronous): config to defaults; clock, ring, sums, held speed and accel go to zero.

module hall_period_speed_meter import hpsm_pkg::*; #(
  parameter int SAMPLES       = 8,
  parameter int INTERVAL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     tick,
  input  logic                     pulse,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [SPEED_W-1:0]       speed_centi_kmh,
  output logic signed [ACCEL_W-1:0] accel_mm_s2,
  output logic                     updated
);

  localparam int SUM_W  = sum_width(SAMPLES, INTERVAL_BITS);
  localparam int DIVD_W = divd_width(SAMPLES, INTERVAL_BITS);
  localparam int DVS_W  = dvs_width(INTERVAL_BITS);

  cfg_t cfg;

  // queue payload: {recompute due, ring sum after this item}
  logic             q_push;
  logic [SUM_W:0]   q_push_data;
  logic             q_pop;
  logic [SUM_W:0]   q_pop_data;
  logic             q_full;
  logic             q_empty;
  logic             item_accept;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_quot;

  // config writes must come only while idle (the block does not enforce it); out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_circumference_mm <= CIRC_RST;
      cfg.pulses_per_rev         <= PPR_RST;
      cfg.update_period_ms       <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CIRC:   cfg.wheel_circumference_mm <= cfg_data[CIRC_W-1:0];
        REG_PPR:    cfg.pulses_per_rev         <= cfg_data[PPR_W-1:0];
        REG_PERIOD: cfg.update_period_ms       <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // the front stalls only on a full queue
  assign item_stall  = q_full;
  assign item_accept = item_valid && !q_full;

  hpsm_front #(
    .SAMPLES       (SAMPLES),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (item_accept),
    .tick      (tick),
    .pulse     (pulse),
    .push      (q_push),
    .push_data (q_push_data)
  );

  hpsm_fifo #(
    .W (SUM_W + 1)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  hpsm_div #(
    .DIVD_W (DIVD_W),
    .DVS_W  (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  hpsm_back #(
    .SAMPLES       (SAMPLES),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quot        (div_quot),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .speed_centi_kmh (speed_centi_kmh),
    .accel_mm_s2     (accel_mm_s2),
    .updated         (updated)
  );

  // the divider is never restarted mid-run
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a quotient is only flagged at the end of a run
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    div_done |-> $past(div_busy))
    else $error("divider done without a run");

endmodule

/* rtl/hpsm_fifo.sv */
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps

module hpsm_fifo import hpsm_pkg::*; #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

/* rtl/hpsm_front.sv */
// Front end: ms clock, edge interval ring with running sum, update due check.
`timescale 1ns / 1ps

module hpsm_front import hpsm_pkg::*; #(
  parameter int SAMPLES       = 8,
  parameter int INTERVAL_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  cfg_t                                          cfg,
  input  logic                                          accept,
  input  logic                                          tick,
  input  logic                                          pulse,
  output logic                                          push,
  output logic [sum_width(SAMPLES, INTERVAL_BITS):0]    push_data
);

  localparam int POS_W = pos_width(SAMPLES);
  localparam int SUM_W = sum_width(SAMPLES, INTERVAL_BITS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES - 1);
  localparam logic [CLK_W-1:0] IV_LIM =
    CLK_W'((64'd1 << INTERVAL_BITS) - 64'd1);

  logic [CLK_W-1:0]         clock_ms;
  logic [CLK_W-1:0]         last_edge_time;
  logic [CLK_W-1:0]         last_update_time;
  logic [POS_W-1:0]         ring_pos;
  logic [POS_W-1:0]         ring_pos_next;
  logic [SUM_W-1:0]         ring_sum;
  logic [SUM_W-1:0]         ring_sum_next;
  logic [INTERVAL_BITS-1:0] ring [SAMPLES];
  logic [SAMPLES-1:0]       ring_valid;
  logic [INTERVAL_BITS-1:0] ring_old;

  logic [CLK_W-1:0]         clock_next;
  logic [CLK_W-1:0]         iv_raw;
  logic [INTERVAL_BITS-1:0] iv;
  logic                     edge_wr;
  logic [PERIOD_W-1:0]      period;
  logic                     due;

  always_comb begin
    clock_next    = clock_ms + CLK_W'(tick);
    iv_raw        = clock_next - last_edge_time;
    iv            = (iv_raw > IV_LIM) ? IV_LIM[INTERVAL_BITS-1:0]
                                      : iv_raw[INTERVAL_BITS-1:0];
    edge_wr       = accept && pulse;
    ring_pos_next = ring_pos;
    if (edge_wr) begin
      ring_pos_next = (ring_pos == POS_LAST) ? '0 : ring_pos + POS_W'(1);
    end
    // ring_old always holds the entry at ring_pos, so the sum updates in place
    ring_sum_next = ring_sum - SUM_W'(ring_old) + SUM_W'(iv);
    period        = (cfg.update_period_ms == '0) ? PERIOD_W'(1) : cfg.update_period_ms;
    due           = (clock_next - last_update_time) >= CLK_W'(period);
  end

  assign push      = accept;
  assign push_data = {due, edge_wr ? ring_sum_next : ring_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms         <= '0;
      last_edge_time   <= '0;
      last_update_time <= '0;
      ring_pos         <= '0;
      ring_sum         <= '0;
      ring_valid       <= '0;
      ring_old         <= '0;
    end else begin
      if (accept) begin
        clock_ms <= clock_next;
        if (due) last_update_time <= clock_next;
      end
      if (edge_wr) begin
        last_edge_time       <= clock_next;
        ring_sum             <= ring_sum_next;
        ring_valid[ring_pos] <= 1'b1;
      end
      ring_pos <= ring_pos_next;
      // registered read of the next slot, write-first on a collision
      if (edge_wr && (ring_pos == ring_pos_next)) begin
        ring_old <= iv;
      end else if (ring_valid[ring_pos_next]) begin
        ring_old <= ring[ring_pos_next];
      end else begin
        ring_old <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (edge_wr) ring[ring_pos] <= iv;
  end

endmodule

/* rtl/hpsm_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module hpsm_div import hpsm_pkg::*; #(
  parameter int DIVD_W = 31,
  parameter int DVS_W  = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] acc;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [DVS_W-1:0]  rem_nx;

  always_comb begin
    rem_sh = {rem, acc[DIVD_W-1]};
    fits   = rem_sh >= {1'b0, dvs};
    rem_nx = fits ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
  end

  assign quot = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (busy && (cnt == CNT_W'(1))) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= CNT_W'(DIVD_W);
    end else if (busy) begin
      acc <= {acc[DIVD_W-2:0], fits};
      rem <= rem_nx;
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

/* rtl/hpsm_back.sv */
// Back end: ring average, speed and acceleration via the shared divider, result register.
`timescale 1ns / 1ps

module hpsm_back import hpsm_pkg::*; #(
  parameter int SAMPLES       = 8,
  parameter int INTERVAL_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  cfg_t                                          cfg,
  input  logic                                          q_empty,
  input  logic [sum_width(SAMPLES, INTERVAL_BITS):0]    q_data,
  output logic                                          q_pop,
  output logic                                          div_start,
  output logic [divd_width(SAMPLES, INTERVAL_BITS)-1:0] div_dividend,
  output logic [dvs_width(INTERVAL_BITS)-1:0]           div_divisor,
  input  logic                                          div_done,
  input  logic [divd_width(SAMPLES, INTERVAL_BITS)-1:0] div_quot,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output logic [SPEED_W-1:0]                            speed_centi_kmh,
  output logic signed [ACCEL_W-1:0]                     accel_mm_s2,
  output logic                                          updated
);

  localparam int SUM_W  = sum_width(SAMPLES, INTERVAL_BITS);
  localparam int DIVD_W = divd_width(SAMPLES, INTERVAL_BITS);
  localparam int DVS_W  = dvs_width(INTERVAL_BITS);
  localparam int DEN_W  = PPR_W + INTERVAL_BITS;

  // floor(sum / SAMPLES) as (sum * ceil(2^AVG_SH / SAMPLES)) >> AVG_SH;
  // exact for every sum below 2^SUM_W since SAMPLES <= 2^pos_width
  localparam int AVG_SH     = SUM_W + pos_width(SAMPLES);
  localparam int RCP_W      = AVG_SH + 1;
  localparam int AVG_PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  back_state_t state, state_next;

  logic [DEN_W-1:0]      den;
  logic [SPEED_W-1:0]    speed_new;
  logic [SPEED_W-1:0]    speed_held;
  logic [ACCEL_W-1:0]    accel_held;
  logic                  acc_neg;
  logic [ACC_PROD_W-1:0] acc_prod;

  logic [SUM_W-1:0]         sum_held;
  logic [INTERVAL_BITS-1:0] avg;
  logic [AVG_PROD_W-1:0]    avg_prod;

  logic                  out_free;
  logic                  q_upd;
  logic [SUM_W-1:0]      q_sum;
  logic [SPEED_NUM_W-1:0] num;
  logic [PERIOD_W-1:0]   period;
  logic [ACC_DVS_W-1:0]  acc_dvs;
  logic [SPEED_W-1:0]    speed_mag;
  logic [SPEED_W-1:0]    speed_sat;
  logic [ACCEL_W-1:0]    accel_sat;
  logic                  load_hold;
  logic                  load_new;

  always_comb begin
    out_free  = !result_valid || !result_stall;
    q_upd     = q_data[SUM_W];
    q_sum     = q_data[SUM_W-1:0];
    avg_prod  = AVG_PROD_W'(sum_held) * AVG_PROD_W'(AVG_RCP);
    den       = DEN_W'(cfg.pulses_per_rev) * DEN_W'(avg);
    num       = SPEED_NUM_W'(cfg.wheel_circumference_mm) * SPEED_NUM_W'(SPEED_SCALE);
    period    = (cfg.update_period_ms == '0) ? PERIOD_W'(1) : cfg.update_period_ms;
    acc_dvs   = ACC_DVS_W'(period) * ACC_DVS_W'(ACC_DVS_SCALE);
    speed_mag = (speed_new < speed_held) ? speed_held - speed_new
                                         : speed_new - speed_held;
    speed_sat = (div_quot > DIVD_W'(SPEED_MAX)) ? SPEED_MAX : div_quot[SPEED_W-1:0];
    // truncation toward zero: divide the magnitude, then restore the sign
    if (acc_neg) begin
      accel_sat = (div_quot > DIVD_W'(ACCEL_MIN_MAG)) ? ACCEL_NEG_SAT
                                                      : -div_quot[ACCEL_W-1:0];
    end else begin
      accel_sat = (div_quot > DIVD_W'(ACCEL_MAX_MAG)) ? ACCEL_POS_SAT
                                                      : div_quot[ACCEL_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && q_upd) state_next = B_AVG;
      end
      B_AVG: begin
        state_next = B_DEN;
      end
      B_DEN: begin
        state_next = (den == '0) ? B_ACC_MUL : B_SPEED;
      end
      B_SPEED: begin
        if (div_done) state_next = B_ACC_MUL;
      end
      B_ACC_MUL: begin
        state_next = B_ACC_START;
      end
      B_ACC_START: begin
        state_next = B_ACC_DIV;
      end
      B_ACC_DIV: begin
        if (div_done) state_next = B_OUT;
      end
      B_OUT: begin
        if (out_free) state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    load_hold    = 1'b0;
    load_new     = 1'b0;
    case (state)
      B_IDLE: begin
        q_pop     = !q_empty && (q_upd || out_free);
        load_hold = !q_empty && !q_upd && out_free;
      end
      B_DEN: begin
        div_start    = (den != '0);
        div_dividend = DIVD_W'(num);
        div_divisor  = DVS_W'(den);
      end
      B_ACC_START: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'(acc_prod);
        div_divisor  = DVS_W'(acc_dvs);
      end
      B_OUT: begin
        load_new = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      speed_held <= '0;
      accel_held <= '0;
    end else begin
      state <= state_next;
      if (state == B_ACC_DIV && div_done) begin
        speed_held <= speed_new;
        accel_held <= accel_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty && q_upd) sum_held <= q_sum;
    if (state == B_AVG) avg <= avg_prod[AVG_SH +: INTERVAL_BITS];
    if (state == B_DEN && den == '0) speed_new <= '0;
    if (state == B_SPEED && div_done) speed_new <= speed_sat;
    if (state == B_ACC_MUL) begin
      acc_neg  <= speed_new < speed_held;
      acc_prod <= ACC_PROD_W'(speed_mag) * ACC_PROD_W'(ACC_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_hold || load_new) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hold || load_new) begin
      speed_centi_kmh <= speed_held;
      accel_mm_s2     <= accel_held;
      updated         <= load_new;
    end
  end

endmodule
